// ===== rtl/dlte_pkg.sv =====
// Shared types and constants of the dense layer training engine.
// No dependencies; the RTL files refer to it by scoped names, the sim files import it.
`default_nettype none
package dlte_pkg;

  localparam int NODE_COUNT = 16;
  localparam int NUM_INPUTS = 32;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int IN_W       = $clog2(NUM_INPUTS);
  localparam int ADDR_W     = NODE_W + IN_W;
  localparam int DATA_W     = 16;
  localparam int GRAD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int LR_W       = 16;
  localparam int LAMBDA_W   = 15;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_W     = 9;
  localparam int OP_W       = 3;
  localparam int DRAIN_LEN  = 5;
  localparam int DRAIN_W    = $clog2(DRAIN_LEN);
  localparam int LEAK_SLOPE = 655;

  localparam logic [KIND_W-1:0] KIND_LINEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELU   = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_WR_WEIGHT = 3'd0,
    OP_WR_BIAS   = 3'd1,
    OP_LD_INPUT  = 3'd2,
    OP_ACTIVATE  = 3'd3,
    OP_LD_ERROR  = 3'd4,
    OP_BACKPROP  = 3'd5,
    OP_UPDATE    = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_KIND    = 2'd0,
    CFG_LEARNING_RATE = 2'd1,
    CFG_SHRINK_LAMBDA = 2'd2,
    CFG_LASSO_ENABLE  = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              valid;
    op_e               ph;
    logic              first;
    logic              last;
    logic [NODE_W-1:0] n;
    logic [IN_W-1:0]   i;
  } issue_t;

  typedef struct packed {
    issue_t            issue;
    logic              load_we;
    op_e               load_op;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              err_clr;
    logic              emit_we;
    logic [IN_W-1:0]   emit_idx;
    logic              emit_last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dlte_if.sv =====
// Request and result channel interfaces of the dense layer engine.
// Depends on dlte_pkg for field widths.
`default_nettype none
interface dlte_in_if;
  logic                               valid;
  logic                               ready;
  logic [dlte_pkg::OP_W-1:0]          opcode;
  logic [dlte_pkg::SLOT_W-1:0]        slot;
  logic signed [dlte_pkg::DATA_W-1:0] value;
  modport source (output valid, opcode, slot, value, input ready);
  modport sink   (input valid, opcode, slot, value, output ready);
endinterface

interface dlte_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dlte_pkg::DATA_W-1:0] result_value;
  logic [dlte_pkg::IN_W-1:0]          result_index;
  logic                               last;
  modport source (output valid, result_value, result_index, last, input ready);
  modport sink   (input valid, result_value, result_index, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/dlte_ctrl.sv =====
// Sequencer of the dense layer engine: gradient clearing pass, weight walk,
// pipeline drain and result emission. Depends on dlte_pkg.
`default_nettype none
module dlte_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [dlte_pkg::OP_W-1:0]       in_opcode_i,
  output logic                                 in_ready_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output dlte_pkg::cmd_t                       cmd_o
);

  dlte_pkg::state_e state_q, state_d;
  dlte_pkg::op_e    ph_q, ph_d;
  logic [dlte_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  logic [dlte_pkg::IN_W-1:0]   ecnt_q, ecnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept, run_op, cnt_end, drain_end, emit_go, emit_end;
  logic [dlte_pkg::IN_W-1:0]   emit_max;
  dlte_pkg::op_e               req_op;

  assign req_op    = dlte_pkg::op_e'(in_opcode_i);
  assign accept    = (state_q == dlte_pkg::ST_IDLE) && in_valid_i;
  assign run_op    = (req_op == dlte_pkg::OP_ACTIVATE) || (req_op == dlte_pkg::OP_BACKPROP)
                     || (req_op == dlte_pkg::OP_UPDATE);
  assign cnt_end   = (cnt_q == {dlte_pkg::ADDR_W{1'b1}});
  assign drain_end = (cnt_q[dlte_pkg::DRAIN_W-1:0] == dlte_pkg::DRAIN_W'(dlte_pkg::DRAIN_LEN - 1));
  assign emit_max  = (ph_q == dlte_pkg::OP_ACTIVATE) ? dlte_pkg::IN_W'(dlte_pkg::NODE_COUNT - 1)
                                                    : dlte_pkg::IN_W'(dlte_pkg::NUM_INPUTS - 1);
  assign emit_go   = (state_q == dlte_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_end  = emit_go && (ecnt_q == emit_max);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlte_pkg::ST_CLEAR: if (cnt_end) state_d = dlte_pkg::ST_IDLE;
      dlte_pkg::ST_IDLE:  if (accept && run_op) state_d = dlte_pkg::ST_RUN;
      dlte_pkg::ST_RUN:   if (cnt_end) state_d = dlte_pkg::ST_DRAIN;
      dlte_pkg::ST_DRAIN: begin
        if (drain_end) begin
          state_d = (ph_q == dlte_pkg::OP_UPDATE) ? dlte_pkg::ST_IDLE : dlte_pkg::ST_EMIT;
        end
      end
      dlte_pkg::ST_EMIT:  if (emit_end) state_d = dlte_pkg::ST_IDLE;
      default:            state_d = dlte_pkg::ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd_o       = '0;
    cnt_d       = cnt_q;
    ecnt_d      = ecnt_q;
    ph_d        = ph_q;
    in_ready_o  = (state_q == dlte_pkg::ST_IDLE);
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    cmd_o.load_op = req_op;
    unique case (state_q)
      dlte_pkg::ST_CLEAR: begin
        cmd_o.clr_we   = 1'b1;
        cmd_o.clr_addr = cnt_q;
        cnt_d          = cnt_q + 1'b1;
      end
      dlte_pkg::ST_IDLE: begin
        cmd_o.load_we = accept && !run_op;
        if (accept && run_op) begin
          ph_d  = req_op;
          cnt_d = '0;
        end
      end
      dlte_pkg::ST_RUN: begin
        cmd_o.issue.valid = 1'b1;
        cmd_o.issue.ph    = ph_q;
        if (ph_q == dlte_pkg::OP_BACKPROP) begin
          // input outer, node inner: one error sum completes per input
          cmd_o.issue.n     = cnt_q[dlte_pkg::NODE_W-1:0];
          cmd_o.issue.i     = cnt_q[dlte_pkg::ADDR_W-1:dlte_pkg::NODE_W];
          cmd_o.issue.first = (cmd_o.issue.n == '0);
          cmd_o.issue.last  = (cmd_o.issue.n == {dlte_pkg::NODE_W{1'b1}});
        end else begin
          cmd_o.issue.n     = cnt_q[dlte_pkg::ADDR_W-1:dlte_pkg::IN_W];
          cmd_o.issue.i     = cnt_q[dlte_pkg::IN_W-1:0];
          cmd_o.issue.first = (cmd_o.issue.i == '0);
          cmd_o.issue.last  = (cmd_o.issue.i == {dlte_pkg::IN_W{1'b1}});
        end
        cnt_d = cnt_q + 1'b1;
      end
      dlte_pkg::ST_DRAIN: begin
        cnt_d = drain_end ? '0 : cnt_q + 1'b1;
        if (drain_end) begin
          ecnt_d        = '0;
          cmd_o.err_clr = (ph_q == dlte_pkg::OP_BACKPROP);
        end
      end
      dlte_pkg::ST_EMIT: begin
        cmd_o.emit_idx  = ecnt_q;
        cmd_o.emit_last = (ecnt_q == emit_max);
        cmd_o.emit_we   = emit_go;
        if (emit_go) begin
          out_valid_d = 1'b1;
          ecnt_d      = ecnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlte_pkg::ST_CLEAR;
      ph_q        <= dlte_pkg::OP_ACTIVATE;
      cnt_q       <= '0;
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      ecnt_q      <= ecnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dlte_datapath.sv =====
// Stores, configuration registers and the shared multiply-accumulate
// pipeline of the dense layer engine. Depends on dlte_pkg.
`default_nettype none
module dlte_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire dlte_pkg::cmd_t                       cmd_i,
  input  wire logic [dlte_pkg::SLOT_W-1:0]          slot_i,
  input  wire logic signed [dlte_pkg::DATA_W-1:0]   value_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dlte_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [dlte_pkg::LR_W-1:0]            cfg_wdata_i,
  output logic signed [dlte_pkg::DATA_W-1:0]       result_value_o,
  output logic [dlte_pkg::IN_W-1:0]                result_index_o,
  output logic                                     last_o
);

  localparam int DW = dlte_pkg::DATA_W;
  localparam int GW = dlte_pkg::GRAD_W;
  localparam int AW = dlte_pkg::ACC_W;
  localparam int NW = dlte_pkg::NODE_W;
  localparam int IW = dlte_pkg::IN_W;
  localparam int MW = dlte_pkg::ADDR_W;
  localparam int PBW = GW + dlte_pkg::LR_W + 1;
  localparam int LKW = AW + 11;
  localparam int SLOT_HI = dlte_pkg::SLOT_W - 1;

  function automatic logic signed [DW-1:0] sat16(input logic signed [LKW-1:0] x);
    logic signed [LKW-1:0] hi, lo;
    hi = LKW'(32767);
    lo = -LKW'(32768);
    if (x > hi) return DW'(32767);
    if (x < lo) return 16'sh8000;
    return x[DW-1:0];
  endfunction

  function automatic logic signed [GW-1:0] sat32(input logic signed [GW:0] x);
    if (x[GW] != x[GW-1]) return x[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
    return x[GW-1:0];
  endfunction

  // configuration
  logic [dlte_pkg::KIND_W-1:0]   kind_q;
  logic [dlte_pkg::LR_W-1:0]     lr_q;
  logic [dlte_pkg::LAMBDA_W-1:0] lambda_q;
  logic                          lasso_q;
  logic [dlte_pkg::LAMBDA_W-1:0] thr_q;
  logic [dlte_pkg::LAMBDA_W+dlte_pkg::LR_W-1:0] thr_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= dlte_pkg::KIND_LINEAR;
      lr_q     <= dlte_pkg::LR_W'(655);
      lambda_q <= '0;
      lasso_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (dlte_pkg::cfg_e'(cfg_idx_i))
        dlte_pkg::CFG_LAYER_KIND:    kind_q   <= cfg_wdata_i[dlte_pkg::KIND_W-1:0];
        dlte_pkg::CFG_LEARNING_RATE: lr_q     <= cfg_wdata_i;
        dlte_pkg::CFG_SHRINK_LAMBDA: lambda_q <= cfg_wdata_i[dlte_pkg::LAMBDA_W-1:0];
        dlte_pkg::CFG_LASSO_ENABLE:  lasso_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign thr_prod = (dlte_pkg::LAMBDA_W + dlte_pkg::LR_W)'(lambda_q) * lr_q;
  always_ff @(posedge clk_i) thr_q <= thr_prod[dlte_pkg::LAMBDA_W+dlte_pkg::LR_W-1:dlte_pkg::LR_W];

  // small stores
  logic signed [DW-1:0] input_q   [dlte_pkg::NUM_INPUTS];
  logic signed [DW-1:0] act_q     [dlte_pkg::NODE_COUNT];
  logic signed [DW-1:0] err_q     [dlte_pkg::NODE_COUNT];
  logic signed [DW-1:0] bias_q    [dlte_pkg::NODE_COUNT];
  logic signed [GW-1:0] bgrad_q   [dlte_pkg::NODE_COUNT];
  logic signed [DW-1:0] outbuf_q  [dlte_pkg::NUM_INPUTS];

  // large stores
  logic signed [DW-1:0] wmem [2**MW];
  logic signed [GW-1:0] gmem [2**MW];
  logic signed [DW-1:0] wrd_q;
  logic signed [GW-1:0] grd_q;
  logic                 wm_we, gm_we;
  logic [MW-1:0]        wm_addr, gm_addr, rd_addr;
  logic signed [DW-1:0] wm_data;
  logic signed [GW-1:0] gm_data;

  // stage 0: gated error
  logic signed [DW-1:0]   e_raw, e_gated, a_sel;
  logic signed [DW+10:0]  e_leak;

  assign rd_addr = {cmd_i.issue.n, cmd_i.issue.i};
  assign e_raw   = err_q[cmd_i.issue.n];
  assign e_leak  = e_raw * (DW+11)'(dlte_pkg::LEAK_SLOPE);

  always_comb begin
    e_gated = e_raw;
    if (kind_q == dlte_pkg::KIND_RELU) begin
      if (!(act_q[cmd_i.issue.n] > 0)) e_gated = '0;
    end else if (kind_q != dlte_pkg::KIND_LINEAR) begin
      if (act_q[cmd_i.issue.n] < 0) e_gated = DW'(e_leak >>> 16);
    end
  end

  // stage 1 registers
  logic          s1_valid_q, s1_first_q, s1_last_q;
  dlte_pkg::op_e s1_ph_q;
  logic [NW-1:0] s1_n_q;
  logic [IW-1:0] s1_i_q;
  logic signed [DW-1:0] s1_in_q, s1_e_q, s1_bias_q;
  logic signed [GW-1:0] s1_bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= cmd_i.issue.valid;
  end

  always_ff @(posedge clk_i) begin
    s1_ph_q    <= cmd_i.issue.ph;
    s1_first_q <= cmd_i.issue.first;
    s1_last_q  <= cmd_i.issue.last;
    s1_n_q     <= cmd_i.issue.n;
    s1_i_q     <= cmd_i.issue.i;
    s1_in_q    <= input_q[cmd_i.issue.i];
    s1_e_q     <= e_gated;
    s1_bias_q  <= bias_q[cmd_i.issue.n];
    s1_bg_q    <= bgrad_q[cmd_i.issue.n];
  end

  // stage 1: multipliers
  logic signed [2*DW-1:0] p1;
  logic signed [GW-1:0]   mx;
  logic signed [dlte_pkg::LR_W:0] my, lr_s;
  logic signed [PBW-1:0]  pb, pc;

  assign lr_s  = {1'b0, lr_q};
  assign a_sel = (s1_ph_q == dlte_pkg::OP_ACTIVATE) ? s1_in_q : s1_e_q;
  assign p1    = a_sel * wrd_q;
  assign mx    = (s1_ph_q == dlte_pkg::OP_UPDATE) ? grd_q : GW'(s1_e_q);
  assign my    = (s1_ph_q == dlte_pkg::OP_UPDATE) ? lr_s : (dlte_pkg::LR_W+1)'(s1_in_q);
  assign pb    = mx * my;
  assign pc    = s1_bg_q * lr_s;

  // stage 2 registers
  logic          s2_valid_q, s2_first_q, s2_last_q;
  dlte_pkg::op_e s2_ph_q;
  logic [NW-1:0] s2_n_q;
  logic [IW-1:0] s2_i_q;
  logic signed [2*DW-1:0] s2_p1_q;
  logic signed [PBW-1:0]  s2_pb_q, s2_pc_q;
  logic signed [DW-1:0]   s2_w_q, s2_e_q, s2_bias_q;
  logic signed [GW-1:0]   s2_g_q, s2_bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else         s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s2_ph_q    <= s1_ph_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_n_q     <= s1_n_q;
    s2_i_q     <= s1_i_q;
    s2_p1_q    <= p1;
    s2_pb_q    <= pb;
    s2_pc_q    <= pc;
    s2_w_q     <= wrd_q;
    s2_g_q     <= grd_q;
    s2_e_q     <= s1_e_q;
    s2_bias_q  <= s1_bias_q;
    s2_bg_q    <= s1_bg_q;
  end

  // stage 2: accumulate, gradient and weight write-back
  logic signed [AW-1:0] acc_q, acc_base, acc_d;
  logic signed [GW-1:0] wgrad_new, bgrad_new;
  logic signed [PBW-DW-9:0] dw_step, db_step;
  logic signed [DW-1:0] nw_raw, nw, nb;
  logic signed [DW+1:0] thr_s;
  logic                 s2_bp, s2_upd, s2_acc;

  assign s2_bp  = s2_valid_q && (s2_ph_q == dlte_pkg::OP_BACKPROP);
  assign s2_upd = s2_valid_q && (s2_ph_q == dlte_pkg::OP_UPDATE);
  assign s2_acc = s2_valid_q && (s2_ph_q != dlte_pkg::OP_UPDATE);

  always_comb begin
    if (!s2_first_q)                              acc_base = acc_q;
    else if (s2_ph_q == dlte_pkg::OP_ACTIVATE)    acc_base = AW'(s2_bias_q) <<< 8;
    else                                          acc_base = '0;
  end
  assign acc_d = acc_base + AW'(s2_p1_q);

  assign wgrad_new = sat32((GW+1)'(s2_g_q) + (GW+1)'(s2_pb_q));
  assign bgrad_new = sat32((GW+1)'(s2_bg_q) + ((GW+1)'(s2_e_q) <<< 8));
  assign dw_step   = s2_pb_q[PBW-1:24];
  assign db_step   = s2_pc_q[PBW-1:24];
  assign nw_raw    = sat16(LKW'(s2_w_q) + LKW'(dw_step));
  assign nb        = sat16(LKW'(s2_bias_q) + LKW'(db_step));
  assign thr_s     = (DW+2)'(thr_q);

  always_comb begin
    nw = nw_raw;
    if (lasso_q) begin
      priority if ((DW+2)'(nw_raw) > thr_s)  nw = DW'((DW+2)'(nw_raw) - thr_s);
      else if ((DW+2)'(nw_raw) < -thr_s)     nw = DW'((DW+2)'(nw_raw) + thr_s);
      else                                   nw = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_acc) acc_q <= acc_d;
  end

  // memory write ports
  always_comb begin
    wm_we   = s2_upd || (cmd_i.load_we && (cmd_i.load_op == dlte_pkg::OP_WR_WEIGHT));
    wm_addr = s2_upd ? {s2_n_q, s2_i_q} : slot_i[MW-1:0];
    wm_data = s2_upd ? nw : value_i;
    gm_we   = cmd_i.clr_we || s2_bp || s2_upd;
    gm_addr = cmd_i.clr_we ? cmd_i.clr_addr : {s2_n_q, s2_i_q};
    gm_data = s2_bp ? wgrad_new : '0;
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) wmem[wm_addr] <= wm_data;
    wrd_q <= wmem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (gm_we) gmem[gm_addr] <= gm_data;
    grd_q <= gmem[rd_addr];
  end

  // stages 3 and 4: finalise a node activation or an input error sum
  logic          s3_valid_q, s4_valid_q;
  dlte_pkg::op_e s3_ph_q, s4_ph_q;
  logic [IW-1:0] s3_idx_q, s4_idx_q;
  logic signed [AW-1:0]  s3_fin_q, s4_fin_q;
  logic signed [LKW-1:0] s4_leak_q;
  logic signed [DW-1:0]  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_acc && s2_last_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ph_q   <= s2_ph_q;
    s3_idx_q  <= (s2_ph_q == dlte_pkg::OP_ACTIVATE) ? IW'(s2_n_q) : s2_i_q;
    s3_fin_q  <= acc_d;
    s4_ph_q   <= s3_ph_q;
    s4_idx_q  <= s3_idx_q;
    s4_fin_q  <= s3_fin_q;
    s4_leak_q <= LKW'(s3_fin_q) * LKW'(dlte_pkg::LEAK_SLOPE);
  end

  always_comb begin
    if (s4_ph_q != dlte_pkg::OP_ACTIVATE || kind_q == dlte_pkg::KIND_LINEAR || s4_fin_q > 0)
      res = sat16(LKW'(s4_fin_q >>> 8));
    else if (kind_q == dlte_pkg::KIND_RELU)
      res = '0;
    else
      res = sat16(s4_leak_q >>> 24);
  end

  // small store updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dlte_pkg::NUM_INPUTS; k++) input_q[k] <= '0;
      for (int k = 0; k < dlte_pkg::NODE_COUNT; k++) begin
        act_q[k]   <= '0;
        err_q[k]   <= '0;
        bgrad_q[k] <= '0;
      end
    end else begin
      if (cmd_i.load_we && cmd_i.load_op == dlte_pkg::OP_LD_INPUT && slot_i[SLOT_HI:IW] == '0)
        input_q[slot_i[IW-1:0]] <= value_i;
      if (cmd_i.err_clr) begin
        for (int k = 0; k < dlte_pkg::NODE_COUNT; k++) err_q[k] <= '0;
      end else if (cmd_i.load_we && cmd_i.load_op == dlte_pkg::OP_LD_ERROR
                   && slot_i[SLOT_HI:NW] == '0) begin
        err_q[slot_i[NW-1:0]] <= value_i;
      end
      if (s4_valid_q && s4_ph_q == dlte_pkg::OP_ACTIVATE) act_q[s4_idx_q[NW-1:0]] <= res;
      // bias gradient once per node, on its first input
      if (s2_bp && s2_i_q == '0)  bgrad_q[s2_n_q] <= bgrad_new;
      if (s2_upd && s2_i_q == '0) bgrad_q[s2_n_q] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && cmd_i.load_op == dlte_pkg::OP_WR_BIAS && slot_i[SLOT_HI:NW] == '0)
      bias_q[slot_i[NW-1:0]] <= value_i;
    else if (s2_upd && s2_i_q == '0)
      bias_q[s2_n_q] <= nb;
    if (s4_valid_q) outbuf_q[s4_idx_q] <= res;
    if (cmd_i.emit_we) begin
      result_value_o <= outbuf_q[cmd_i.emit_idx];
      result_index_o <= cmd_i.emit_idx;
      last_o         <= cmd_i.emit_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dense_layer_train_engine_top.sv =====
// Dense layer training engine: a load request is written straight into its store; activate,
// backprop and update walk all 512 weights through one multiply-accumulate
// pipeline, one weight a cycle, then drain the pipeline; the 16 or 32 results
// (none for update) then leave one a cycle while the result side is ready. The one shared
// multiply-accumulate sets the walk. After reset a clearing pass over the
// gradient memory runs before the first request is taken; configuration writes are taken at once.
`default_nettype none
module dense_layer_train_engine_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  dlte_in_if.sink                                  in_req,
  dlte_out_if.source                               out_rsp,
  input  wire logic                                cfg_we_i,
  input  wire logic [dlte_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [dlte_pkg::LR_W-1:0]           cfg_wdata_i
);

  dlte_pkg::cmd_t cmd;
  logic           in_ready, out_valid;

  dlte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_opcode_i (in_req.opcode),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_rsp.ready),
    .cmd_o       (cmd)
  );

  dlte_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .slot_i         (in_req.slot),
    .value_i        (in_req.value),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_value_o (out_rsp.result_value),
    .result_index_o (out_rsp.result_index),
    .last_o         (out_rsp.last)
  );

  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid;

endmodule
`default_nettype wire

// ===== sim/dlte_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the dense layer training engine: watches the request and
// result channels, keeps its own copy of the layer state and compares results.
// Depends on dlte_pkg.
module dlte_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               req_valid_i,
  input  logic                               req_ready_i,
  input  logic [dlte_pkg::OP_W-1:0]          req_opcode_i,
  input  logic [dlte_pkg::SLOT_W-1:0]        req_slot_i,
  input  logic signed [dlte_pkg::DATA_W-1:0] req_value_i,
  input  logic                               rsp_valid_i,
  input  logic                               rsp_ready_i,
  input  logic signed [dlte_pkg::DATA_W-1:0] rsp_value_i,
  input  logic [dlte_pkg::IN_W-1:0]          rsp_index_i,
  input  logic                               rsp_last_i,
  input  logic                               cfg_we_i,
  input  logic [dlte_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dlte_pkg::LR_W-1:0]          cfg_wdata_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import dlte_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IN_W-1:0]          index;
    logic                     last;
  } layer_result_t;

  localparam int NW = NODE_COUNT * NUM_INPUTS;

  longint weights [NW];
  longint biases [NODE_COUNT];
  longint inputs_q [NUM_INPUTS];
  longint acts [NODE_COUNT];
  longint node_err [NODE_COUNT];
  longint wgrad [NW];
  longint bgrad [NODE_COUNT];
  int unsigned kind, rate, lambda, lasso_on;
  layer_result_t expected_results [$];

  assign pending_o = expected_results.size();

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clip16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic push_result(longint v, int idx, bit lst);
    layer_result_t r;
    r.value = v[DATA_W-1:0];
    r.index = idx[IN_W-1:0];
    r.last = lst;
    expected_results = {expected_results, r};
  endtask

  task automatic predict_layer(logic [OP_W-1:0] op, int unsigned slot, longint v);
    longint sum, e, t, d, nw;
    longint esum [NUM_INPUTS];
    bit gate;
    case (op)
      OP_WR_WEIGHT: if (slot < NW) weights[slot] = v;
      OP_WR_BIAS:   if (slot < NODE_COUNT) biases[slot] = v;
      OP_LD_INPUT:  if (slot < NUM_INPUTS) inputs_q[slot] = v;
      OP_LD_ERROR:  if (slot < NODE_COUNT) node_err[slot] = v;
      OP_ACTIVATE: begin
        for (int n = 0; n < NODE_COUNT; n++) begin
          sum = biases[n] * 256;
          for (int i = 0; i < NUM_INPUTS; i++) sum += inputs_q[i] * weights[n*NUM_INPUTS+i];
          if (kind == KIND_LINEAR || sum > 0) acts[n] = clip16(floor_shr(sum, 8));
          else if (kind == KIND_RELU) acts[n] = 0;
          else acts[n] = clip16(floor_shr(sum * LEAK_SLOPE, 24));
          push_result(acts[n], n, n == NODE_COUNT - 1);
        end
      end
      OP_BACKPROP: begin
        foreach (esum[i]) esum[i] = 0;
        for (int n = 0; n < NODE_COUNT; n++) begin
          e = node_err[n];
          gate = 1;
          if (kind == KIND_RELU) gate = acts[n] > 0;
          else if (kind >= 2 && acts[n] < 0) e = floor_shr(e * LEAK_SLOPE, 16);
          if (gate) begin
            for (int i = 0; i < NUM_INPUTS; i++) begin
              esum[i] += e * weights[n*NUM_INPUTS+i];
              wgrad[n*NUM_INPUTS+i] = clip32(wgrad[n*NUM_INPUTS+i] + e * inputs_q[i]);
            end
            bgrad[n] = clip32(bgrad[n] + e * 256);
          end
          node_err[n] = 0;
        end
        for (int i = 0; i < NUM_INPUTS; i++)
          push_result(clip16(floor_shr(esum[i], 8)), i, i == NUM_INPUTS - 1);
      end
      OP_UPDATE: begin
        t = (longint'(lambda) * rate) >> 16;
        for (int w = 0; w < NW; w++) begin
          d = floor_shr(wgrad[w] * rate, 24);
          nw = clip16(weights[w] + d);
          if (lasso_on) begin
            if (nw > t) nw -= t;
            else if (nw < -t) nw += t;
            else nw = 0;
          end
          weights[w] = nw;
          wgrad[w] = 0;
        end
        for (int n = 0; n < NODE_COUNT; n++) begin
          biases[n] = clip16(biases[n] + floor_shr(bgrad[n] * rate, 24));
          bgrad[n] = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    kind = 0; rate = 655; lambda = 0; lasso_on = 0;
    foreach (weights[i]) begin weights[i] = 0; wgrad[i] = 0; end
    foreach (biases[i]) begin
      biases[i] = 0; acts[i] = 0; node_err[i] = 0; bgrad[i] = 0;
    end
    foreach (inputs_q[i]) inputs_q[i] = 0;
  end

  always @(posedge clk_i) begin
    layer_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_LAYER_KIND:    kind = cfg_wdata_i[1:0];
          CFG_LEARNING_RATE: rate = cfg_wdata_i;
          CFG_SHRINK_LAMBDA: lambda = cfg_wdata_i[14:0];
          CFG_LASSO_ENABLE:  lasso_on = cfg_wdata_i[0];
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result at index", rsp_index_i, -1);
        end else begin
          want = expected_results.pop_front();
          if (rsp_value_i !== want.value) report_mismatch("value", rsp_value_i, want.value);
          if (rsp_index_i !== want.index) report_mismatch("index", rsp_index_i, want.index);
          if (rsp_last_i !== want.last) report_mismatch("last", rsp_last_i, want.last);
        end
      end
      if (req_valid_i && req_ready_i)
        predict_layer(req_opcode_i, req_slot_i, longint'(req_value_i));
    end
  end
endmodule

// ===== sim/tb_dense_layer_train_engine_top.sv =====
`timescale 1ns / 1ps
// Stimulus top for the dense layer training engine: drives requests and
// configuration, throttles results, and gives the verdict from dlte_checker.
module tb_dense_layer_train_engine_top;
  import dlte_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i, rst_ni, cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LR_W-1:0] cfg_wdata_i;
  int fail_count, pending, idle_cycles, hold_cycles;
  bit long_hold;

  dlte_in_if  in_req ();
  dlte_out_if out_rsp ();

  dense_layer_train_engine_top dut (
    .clk_i, .rst_ni, .in_req(in_req.sink), .out_rsp(out_rsp.source),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  dlte_checker checker_u (
    .clk_i, .rst_ni,
    .req_valid_i(in_req.valid), .req_ready_i(in_req.ready),
    .req_opcode_i(in_req.opcode), .req_slot_i(in_req.slot), .req_value_i(in_req.value),
    .rsp_valid_i(out_rsp.valid), .rsp_ready_i(out_rsp.ready),
    .rsp_value_i(out_rsp.result_value), .rsp_index_i(out_rsp.result_index),
    .rsp_last_i(out_rsp.last),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, one long hold-off on request.
  initial begin
    out_rsp.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_rsp.ready <= 0;
        hold_cycles = 0;
        while (hold_cycles < 400) begin @(negedge clk_i); hold_cycles++; end
        long_hold = 0;
      end else if (hold_cycles >= 0) begin
        out_rsp.ready <= (gap_len() == 0);
      end
    end
  end

  // Abort when nothing moves for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) || !rst_ni)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Valid stays high between back-to-back requests; drop it only for a gap.
  task automatic send_request(op_e op, int unsigned slot, int v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_req.valid <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_req.valid <= 1;
    in_req.opcode <= op;
    in_req.slot <= slot[SLOT_W-1:0];
    in_req.value <= v[DATA_W-1:0];
    do @(posedge clk_i); while (!in_req.ready);
    @(negedge clk_i);
  endtask

  // Wait for every result and for the block to go idle.
  task automatic drain_results();
    in_req.valid <= 0;
    while (pending != 0 || !in_req.ready) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_e idx, int unsigned v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v[LR_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  // Write every weight and bias so neither store is read unwritten.
  task automatic fill_layer(int wmax);
    for (int w = 0; w < NODE_COUNT * NUM_INPUTS; w++)
      send_request(OP_WR_WEIGHT, w, $signed($urandom_range(0, 2*wmax)) - wmax);
    for (int n = 0; n < NODE_COUNT; n++)
      send_request(OP_WR_BIAS, n, $signed($urandom_range(0, 1024)) - 512);
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) send_request(OP_LD_INPUT, $urandom_range(0, NUM_INPUTS-1), $urandom());
    else if (r < 50) send_request(OP_LD_ERROR, $urandom_range(0, NODE_COUNT-1), $urandom());
    else if (r < 60) send_request(OP_WR_WEIGHT, $urandom_range(0, 511), $urandom());
    else if (r < 65) send_request(OP_WR_BIAS, $urandom_range(0, 511), $urandom());
    else if (r < 75) send_request(OP_ACTIVATE, $urandom(), $urandom());
    else if (r < 85) send_request(OP_BACKPROP, $urandom(), $urandom());
    else if (r < 90) send_request(OP_UPDATE, $urandom(), $urandom());
    else if (r < 95) send_request(op_e'(3'd7), $urandom(), $urandom());
    else send_request(OP_LD_INPUT, $urandom_range(NUM_INPUTS, 511), $urandom());
  endtask

  initial begin
    hold_cycles = 0;
    long_hold = 0;
    in_req.valid = 0;
    in_req.opcode = OP_WR_WEIGHT;
    in_req.slot = 0;
    in_req.value = 0;
    cfg_we_i = 0;
    cfg_idx_i = CFG_LAYER_KIND;
    cfg_wdata_i = 0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    fill_layer(2000);
    // Extremes: full-scale inputs and errors, then every phase.
    send_request(OP_LD_INPUT, 0, 32767);
    send_request(OP_LD_INPUT, NUM_INPUTS-1, -32768);
    send_request(OP_LD_INPUT, 511, 1234);
    send_request(OP_LD_ERROR, 0, -32768);
    send_request(OP_LD_ERROR, NODE_COUNT-1, 32767);
    send_request(OP_LD_ERROR, 0, 500);
    send_request(OP_LD_ERROR, 300, 7);
    send_request(OP_WR_BIAS, 16, 1);
    send_request(OP_WR_WEIGHT, 0, -32768);
    send_request(OP_ACTIVATE, 0, 0);
    send_request(OP_BACKPROP, 0, 0);
    send_request(op_e'(3'd7), 511, -1);
    send_request(OP_UPDATE, 0, 0);
    drain_results();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_cfg(CFG_LAYER_KIND, 1); write_cfg(CFG_LEARNING_RATE, 65535);
           write_cfg(CFG_SHRINK_LAMBDA, 32767); write_cfg(CFG_LASSO_ENABLE, 1); end
        1: begin write_cfg(CFG_LAYER_KIND, 2); write_cfg(CFG_LEARNING_RATE, 0);
           write_cfg(CFG_SHRINK_LAMBDA, 0); write_cfg(CFG_LASSO_ENABLE, 0); end
        2: begin write_cfg(CFG_LAYER_KIND, 3); write_cfg(CFG_LEARNING_RATE, $urandom());
           write_cfg(CFG_SHRINK_LAMBDA, $urandom_range(0, 300)); write_cfg(CFG_LASSO_ENABLE, 1); end
        3: begin write_cfg(CFG_LAYER_KIND, 0); write_cfg(CFG_LEARNING_RATE, 6000); end
        default: begin write_cfg(CFG_LAYER_KIND, 1); write_cfg(CFG_LASSO_ENABLE, 0); end
      endcase
      // Hold results back while phases queue up behind them.
      if (phase == 1) begin
        long_hold = 1;
        send_request(OP_ACTIVATE, 0, 0);
      end
      for (int k = 0; k < 26; k++) random_request();
      drain_results();
    end

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/dlte_pkg.sv
rtl/dlte_if.sv
rtl/dlte_ctrl.sv
rtl/dlte_datapath.sv
rtl/dense_layer_train_engine_top.sv
sim/dlte_checker.sv
sim/tb_dense_layer_train_engine_top.sv
